@@ design/grid_table_bilinear_interp_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the grid table interpolation unit
// Shared forms of the concurrent checks used at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef GRID_TABLE_BILINEAR_INTERP_UNIT_MACROS_SVH
`define GRID_TABLE_BILINEAR_INTERP_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GTBI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gtbi assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define GTBI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gtbi assertion failed");

`endif

@@ design/gtbi_pkg.sv @@
// ----------------------------------------------------------------------------
// Grid table interpolation package
// Sizes, codes and the types shared by the table store and the sequencer.
// ----------------------------------------------------------------------------
package gtbi_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_PTS  = 32;

  localparam int RW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int PW = $clog2(MAX_PTS);
  localparam int LW = $clog2(MAX_PTS + 1);
  localparam int AW = RW + PW;
  localparam int NW = 49;
  localparam int MW = 48;

  typedef enum logic [1:0] {
    KIND_CLEAR = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_QUERY = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_FULL    = 2'd2,
    ST_ORDER   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_RS_RD,
    S_RS_CHK,
    S_LEN_RD,
    S_LEN_CHK,
    S_PT_RD,
    S_PT_CHK,
    S_MUL1,
    S_MUL2,
    S_DIV,
    S_DIV_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic          row_we;
    logic          len_we;
    logic [RW-1:0] row_waddr;
    logic [31:0]   row_wenergy;
    logic [LW-1:0] row_wlen;
    logic [RW-1:0] row_raddr;
    logic          pt_we;
    logic [AW-1:0] pt_waddr;
    logic [15:0]   pt_wangle;
    logic [15:0]   pt_wvalue;
    logic [AW-1:0] pt_raddr;
  } tbl_req_t;

  typedef struct packed {
    logic [31:0]   row_energy;
    logic [LW-1:0] row_len;
    logic [15:0]   pt_angle;
    logic [15:0]   pt_value;
  } tbl_rsp_t;

endpackage

@@ design/grid_table_bilinear_interp_unit.sv @@
// ----------------------------------------------------------------------------
// Grid table bilinear interpolation unit
// Loads a non-uniform energy by angle table and answers interpolation queries.
// ----------------------------------------------------------------------------
// Each input word is a clear, a load or a query (another kind code does
// nothing and gives an OK result), and each gives one result word. A query
// scans the row energies entry by entry, then the points of two rows, and
// runs three interpolations, each a sum of two products from one shared
// multiplier and a serial divide. The input is stalled while a word is in
// work; a finished result waits in the output register until taken.
module grid_table_bilinear_interp_unit import gtbi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         in_kind_i,
  input  logic [31:0]        in_energy_i,
  input  logic [15:0]        in_angle_i,
  input  logic signed [15:0] in_point_power_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] out_power_o,
  output logic [1:0]         out_status_o
);

`include "grid_table_bilinear_interp_unit_macros.svh"

  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   last_e_q, last_e_d;
  logic [LW-1:0] last_len_q, last_len_d;
  logic [15:0]   last_a_q, last_a_d;
  logic [1:0]    kind_q, kind_d;
  logic [31:0]   e_q, e_d;
  logic [15:0]   t_q, t_d;
  logic [15:0]   v_q, v_d;
  logic [CW-1:0] k_q, k_d;
  logic [31:0]   prev_e_q, prev_e_d;
  logic [31:0]   ehi_q, ehi_d;
  logic [RW-1:0] r_q, r_d;
  logic [1:0]    stage_q, stage_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] j_q, j_d;
  logic [31:0]   x1_q, x1_d, x2_q, x2_d, xq_q, xq_d;
  logic signed [15:0] y1_q, y1_d, y2_q, y2_d, ya_q, ya_d;
  logic signed [NW-1:0] acc_q, acc_d;
  logic signed [15:0] res_power_q, res_power_d;
  logic [1:0]    res_status_q, res_status_d;
  logic          out_valid_q, out_valid_d;
  logic signed [15:0] out_power_q, out_power_d;
  logic [1:0]    out_status_q, out_status_d;

  tbl_req_t      req;
  tbl_rsp_t      rsp;
  logic [RW-1:0] cur_row;
  logic signed [16:0] mul_y;
  logic signed [32:0] mul_x;
  logic signed [49:0] prod;
  logic          div_start, div_done;
  logic signed [15:0] div_quot;

  gtbi_tables u_tables (
    .clk_i (clk_i),
    .req_i (req),
    .rsp_o (rsp)
  );

  gtbi_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (acc_q),
    .den_i   (32'(x2_q - x1_q)),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign cur_row = RW'(r_q + RW'(stage_q[0]));
  assign mul_y   = (state_q == S_MUL1) ? 17'(y1_q) : 17'(y2_q);
  assign mul_x   = (state_q == S_MUL1) ? $signed({1'b0, 32'(x2_q - xq_q)})
                                       : $signed({1'b0, 32'(xq_q - x1_q)});
  assign prod    = mul_y * mul_x;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    last_e_d     = last_e_q;
    last_len_d   = last_len_q;
    last_a_d     = last_a_q;
    kind_d       = kind_q;
    e_d          = e_q;
    t_d          = t_q;
    v_d          = v_q;
    k_d          = k_q;
    prev_e_d     = prev_e_q;
    ehi_d        = ehi_q;
    r_d          = r_q;
    stage_d      = stage_q;
    len_d        = len_q;
    j_d          = j_q;
    x1_d         = x1_q;
    x2_d         = x2_q;
    xq_d         = xq_q;
    y1_d         = y1_q;
    y2_d         = y2_q;
    ya_d         = ya_q;
    acc_d        = acc_q;
    res_power_d  = res_power_q;
    res_status_d = res_status_q;
    out_power_d  = out_power_q;
    out_status_d = out_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    div_start    = 1'b0;
    req             = '0;
    req.row_raddr   = (state_q == S_LEN_RD) ? cur_row : k_q[RW-1:0];
    req.pt_raddr    = {cur_row, j_q[PW-1:0]};
    req.row_wenergy = e_q;
    req.pt_wangle   = t_q;
    req.pt_wvalue   = v_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          kind_d  = in_kind_i;
          e_d     = in_energy_i;
          t_d     = in_angle_i;
          v_d     = in_point_power_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        res_power_d  = '0;
        res_status_d = ST_OK;
        state_d      = S_DONE;
        case (kind_q)
          KIND_CLEAR: count_d = '0;
          KIND_LOAD: begin
            if (count_q == '0 || e_q != last_e_q) begin
              if (count_q != '0 && e_q < last_e_q) begin
                res_status_d = ST_ORDER;
              end else if (count_q >= CW'(MAX_ROWS)) begin
                res_status_d = ST_FULL;
              end else begin
                req.row_we    = 1'b1;
                req.len_we    = 1'b1;
                req.row_waddr = count_q[RW-1:0];
                req.row_wlen  = LW'(1);
                req.pt_we     = 1'b1;
                req.pt_waddr  = {count_q[RW-1:0], PW'(0)};
                last_e_d      = e_q;
                last_len_d    = LW'(1);
                last_a_d      = t_q;
                count_d       = CW'(count_q + CW'(1));
              end
            end else if (last_len_q >= LW'(MAX_PTS)) begin
              res_status_d = ST_FULL;
            end else if (t_q <= last_a_q) begin
              res_status_d = ST_ORDER;
            end else begin
              req.len_we    = 1'b1;
              req.row_waddr = RW'(count_q - CW'(1));
              req.row_wlen  = LW'(last_len_q + LW'(1));
              req.pt_we     = 1'b1;
              req.pt_waddr  = {RW'(count_q - CW'(1)), last_len_q[PW-1:0]};
              last_len_d    = LW'(last_len_q + LW'(1));
              last_a_d      = t_q;
            end
          end
          KIND_QUERY: begin
            if (count_q < CW'(2)) begin
              res_status_d = ST_OUTSIDE;
            end else begin
              k_d     = '0;
              state_d = S_RS_RD;
            end
          end
          default: ;
        endcase
      end
      S_RS_RD: state_d = S_RS_CHK;
      S_RS_CHK: begin
        if (e_q < rsp.row_energy) begin
          if (k_q == '0) begin
            res_power_d  = '0;
            res_status_d = ST_OUTSIDE;
            state_d      = S_DONE;
          end else begin
            r_d     = RW'(k_q - CW'(1));
            ehi_d   = rsp.row_energy;
            stage_d = 2'd0;
            state_d = S_LEN_RD;
          end
        end else begin
          prev_e_d = rsp.row_energy;
          if (k_q == CW'(count_q - CW'(1))) begin
            res_power_d  = '0;
            res_status_d = ST_OUTSIDE;
            state_d      = S_DONE;
          end else begin
            k_d     = CW'(k_q + CW'(1));
            state_d = S_RS_RD;
          end
        end
      end
      S_LEN_RD: state_d = S_LEN_CHK;
      S_LEN_CHK: begin
        if (rsp.row_len < LW'(2)) begin
          res_power_d  = '0;
          res_status_d = ST_OUTSIDE;
          state_d      = S_DONE;
        end else begin
          len_d   = rsp.row_len;
          j_d     = '0;
          state_d = S_PT_RD;
        end
      end
      S_PT_RD: state_d = S_PT_CHK;
      S_PT_CHK: begin
        if (t_q < rsp.pt_angle) begin
          if (j_q == '0) begin
            res_power_d  = '0;
            res_status_d = ST_OUTSIDE;
            state_d      = S_DONE;
          end else begin
            x2_d    = {16'd0, rsp.pt_angle};
            y2_d    = rsp.pt_value;
            xq_d    = {16'd0, t_q};
            state_d = S_MUL1;
          end
        end else begin
          x1_d = {16'd0, rsp.pt_angle};
          y1_d = rsp.pt_value;
          if (j_q == LW'(len_q - LW'(1))) begin
            res_power_d  = '0;
            res_status_d = ST_OUTSIDE;
            state_d      = S_DONE;
          end else begin
            j_d     = LW'(j_q + LW'(1));
            state_d = S_PT_RD;
          end
        end
      end
      S_MUL1: begin
        acc_d   = NW'(prod);
        state_d = S_MUL2;
      end
      S_MUL2: begin
        acc_d   = NW'(acc_q + NW'(prod));
        state_d = S_DIV;
      end
      S_DIV: begin
        div_start = 1'b1;
        state_d   = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          case (stage_q)
            2'd0: begin
              ya_d    = div_quot;
              stage_d = 2'd1;
              state_d = S_LEN_RD;
            end
            2'd1: begin
              x1_d    = prev_e_q;
              x2_d    = ehi_q;
              xq_d    = e_q;
              y1_d    = ya_q;
              y2_d    = div_quot;
              stage_d = 2'd2;
              state_d = S_MUL1;
            end
            default: begin
              res_power_d  = div_quot;
              res_status_d = ST_OK;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_power_d  = res_power_q;
          out_status_d = res_status_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    last_e_q     <= last_e_d;
    last_len_q   <= last_len_d;
    last_a_q     <= last_a_d;
    kind_q       <= kind_d;
    e_q          <= e_d;
    t_q          <= t_d;
    v_q          <= v_d;
    k_q          <= k_d;
    prev_e_q     <= prev_e_d;
    ehi_q        <= ehi_d;
    r_q          <= r_d;
    stage_q      <= stage_d;
    len_q        <= len_d;
    j_q          <= j_d;
    x1_q         <= x1_d;
    x2_q         <= x2_d;
    xq_q         <= xq_d;
    y1_q         <= y1_d;
    y2_q         <= y2_d;
    ya_q         <= ya_d;
    acc_q        <= acc_d;
    res_power_q  <= res_power_d;
    res_status_q <= res_status_d;
    out_power_q  <= out_power_d;
    out_status_q <= out_status_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign out_power_o  = out_power_q;
  assign out_status_o = out_status_q;

  `GTBI_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  `GTBI_ASSERT_SAME(a_fail_zero, out_valid_o && out_status_o != ST_OK, out_power_o == '0)
  `GTBI_ASSERT_SAME(a_count_bound, 1'b1, count_q <= CW'(MAX_ROWS))
  `GTBI_ASSERT_SAME(a_div_in_wait, div_done, state_q == S_DIV_WAIT)

endmodule

@@ design/gtbi_tables.sv @@
// ----------------------------------------------------------------------------
// Grid table store
// Row energies, row lengths and point angle and value memories, each with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module gtbi_tables import gtbi_pkg::*; (
  input  logic     clk_i,
  input  tbl_req_t req_i,
  output tbl_rsp_t rsp_o
);

  logic [31:0]   row_energy_mem [MAX_ROWS];
  logic [LW-1:0] row_len_mem    [MAX_ROWS];
  logic [15:0]   pt_angle_mem   [MAX_ROWS*MAX_PTS];
  logic [15:0]   pt_value_mem   [MAX_ROWS*MAX_PTS];

  always_ff @(posedge clk_i) begin
    if (req_i.row_we) begin
      row_energy_mem[req_i.row_waddr] <= req_i.row_wenergy;
    end
    if (req_i.len_we) begin
      row_len_mem[req_i.row_waddr] <= req_i.row_wlen;
    end
    if (req_i.pt_we) begin
      pt_angle_mem[req_i.pt_waddr] <= req_i.pt_wangle;
      pt_value_mem[req_i.pt_waddr] <= req_i.pt_wvalue;
    end
    rsp_o.row_energy <= row_energy_mem[req_i.row_raddr];
    rsp_o.row_len    <= row_len_mem[req_i.row_raddr];
    rsp_o.pt_angle   <= pt_angle_mem[req_i.pt_raddr];
    rsp_o.pt_value   <= pt_value_mem[req_i.pt_raddr];
  end

endmodule

@@ design/gtbi_divider.sv @@
// ----------------------------------------------------------------------------
// Serial signed divider
// Restoring division of a signed numerator by a positive divisor, one
// quotient bit per cycle, with the quotient truncated toward zero.
// ----------------------------------------------------------------------------
module gtbi_divider import gtbi_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic [31:0]         den_i,
  output logic                done_o,
  output logic signed [15:0]  quot_o
);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [MW-1:0] mag_q, mag_d;
  logic [31:0]   rem_q, rem_d;
  logic [31:0]   den_q, den_d;
  logic          neg_q, neg_d;
  logic [32:0]   trial;
  logic [NW-1:0] num_abs;
  logic [16:0]   qmag;

  always_comb begin
    num_abs = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    trial   = {rem_q, mag_q[MW-1]};
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    mag_d   = mag_q;
    rem_d   = rem_q;
    den_d   = den_q;
    neg_d   = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mag_d  = num_abs[MW-1:0];
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[NW-1];
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = 32'(trial - {1'b0, den_q});
        mag_d = {mag_q[MW-2:0], 1'b1};
      end else begin
        rem_d = trial[31:0];
        mag_d = {mag_q[MW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'(MW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  assign qmag   = neg_q ? 17'(-mag_q[16:0]) : mag_q[16:0];
  assign quot_o = qmag[15:0];
  assign done_o = done_q;

endmodule

@@ tb/sv/grid_table_bilinear_interp_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid table bilinear interpolation unit testbench
// Builds energy by angle tables through load words, queries them, and compares
// each result word with a behavioral prediction of the table and interpolation.
// ----------------------------------------------------------------------------
module grid_table_bilinear_interp_unit_tb import gtbi_pkg::*;;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        energy;
    logic [15:0]        angle;
    logic signed [15:0] point_power;
  } grid_word_t;

  typedef struct packed {
    logic signed [15:0] power;
    logic [1:0]         status;
  } interp_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         in_kind_i;
  logic [31:0]        in_energy_i;
  logic [15:0]        in_angle_i;
  logic signed [15:0] in_point_power_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] out_power_o;
  logic [1:0]         out_status_o;

  grid_table_bilinear_interp_unit i_dut (.*);

  grid_word_t   pending_words[$];
  interp_word_t expected_results[$];
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  hold_cycles;
  int unsigned  error_count;

  logic [31:0] tbl_energy[MAX_ROWS];
  int          tbl_length[MAX_ROWS];
  logic [15:0] tbl_angle[MAX_ROWS][MAX_PTS];
  int          tbl_value[MAX_ROWS][MAX_PTS];
  int          tbl_rows;

  function automatic longint lerp_trunc(longint x, longint x1, longint x2,
                                        longint y1, longint y2);
    return (y1 * (x2 - x) + y2 * (x - x1)) / (x2 - x1);
  endfunction

  function automatic bit row_value(int r, longint t, output longint res);
    res = 0;
    for (int j = 0; j + 1 < tbl_length[r]; j++) begin
      if (t >= tbl_angle[r][j] && t < tbl_angle[r][j+1]) begin
        res = lerp_trunc(t, tbl_angle[r][j], tbl_angle[r][j+1],
                         tbl_value[r][j], tbl_value[r][j+1]);
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic interp_word_t predict_word(grid_word_t w);
    interp_word_t o;
    longint y1, y2;
    int r;
    o.power = '0;
    o.status = ST_OK;
    if (w.kind == KIND_CLEAR) begin
      tbl_rows = 0;
    end else if (w.kind == KIND_LOAD) begin
      if (tbl_rows == 0 || w.energy != tbl_energy[tbl_rows-1]) begin
        if (tbl_rows != 0 && w.energy < tbl_energy[tbl_rows-1]) begin
          o.status = ST_ORDER;
        end else if (tbl_rows >= MAX_ROWS) begin
          o.status = ST_FULL;
        end else begin
          tbl_energy[tbl_rows] = w.energy;
          tbl_length[tbl_rows] = 1;
          tbl_angle[tbl_rows][0] = w.angle;
          tbl_value[tbl_rows][0] = w.point_power;
          tbl_rows++;
        end
      end else begin
        r = tbl_rows - 1;
        if (tbl_length[r] >= MAX_PTS) begin
          o.status = ST_FULL;
        end else if (w.angle <= tbl_angle[r][tbl_length[r]-1]) begin
          o.status = ST_ORDER;
        end else begin
          tbl_angle[r][tbl_length[r]] = w.angle;
          tbl_value[r][tbl_length[r]] = w.point_power;
          tbl_length[r]++;
        end
      end
    end else if (w.kind == KIND_QUERY) begin
      o.status = ST_OUTSIDE;
      for (int i = 0; i + 1 < tbl_rows; i++) begin
        if (w.energy >= tbl_energy[i] && w.energy < tbl_energy[i+1]) begin
          if (row_value(i, w.angle, y1) && row_value(i + 1, w.angle, y2)) begin
            o.power = 16'(lerp_trunc(w.energy, tbl_energy[i], tbl_energy[i+1], y1, y2));
            o.status = ST_OK;
          end
          break;
        end
      end
    end
    return o;
  endfunction

  function automatic grid_word_t make_word(logic [1:0] k, logic [31:0] e,
                                           logic [15:0] a, logic [15:0] p);
    grid_word_t w;
    w.kind = k;
    w.energy = e;
    w.angle = a;
    w.point_power = p;
    return w;
  endfunction

  task automatic push_word(grid_word_t w);
    pending_words = {pending_words, w};
  endtask

  // One table of random shape, followed by queries mostly inside it.
  task automatic push_random_table(int rows, int pts);
    logic [31:0] e;
    logic [31:0] step;
    int a;
    logic [31:0] e_lo;
    logic [31:0] e_hi;
    push_word(make_word(KIND_CLEAR, $urandom, 16'($urandom), 16'($urandom)));
    step = ($urandom_range(0, 3) == 0) ? 32'h3FFF_FFFF : $urandom_range(1, 5000);
    e = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, 100000);
    e_lo = e;
    for (int r = 0; r < rows; r++) begin
      a = $urandom_range(0, 200);
      for (int p = 0; p < pts; p++) begin
        push_word(make_word(KIND_LOAD, e, 16'(a), 16'($urandom)));
        if ($urandom_range(0, 15) == 0)
          push_word(make_word(KIND_LOAD, e, 16'(a - $urandom_range(0, 3)),
                              16'($urandom)));
        a += $urandom_range(1, 65535 / (pts + 1));
      end
      e_hi = e;
      if (r + 1 < rows) e = e + $urandom_range(1, step);
    end
    if ($urandom_range(0, 5) == 0)
      push_word(make_word(KIND_LOAD, e_lo - 1, 16'($urandom), 16'($urandom)));
    for (int q = 0; q < 8; q++) begin
      if ($urandom_range(0, 9) == 0)
        push_word(make_word(KIND_QUERY, $urandom, 16'($urandom), 16'($urandom)));
      else
        push_word(make_word(KIND_QUERY, e_lo + $urandom_range(0, e_hi - e_lo),
                            16'($urandom_range(0, 65535)), 16'($urandom)));
    end
    if ($urandom_range(0, 9) == 0)
      push_word(make_word(2'd3, $urandom, 16'($urandom), 16'($urandom)));
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (500) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
  end

  always #1 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_kind_i <= '0;
      in_energy_i <= '0;
      in_angle_i <= '0;
      in_point_power_i <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results = {expected_results, predict_word(pending_words.pop_front())};
      end
      if ((!in_valid_i || !in_stall_o) && pending_words.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        grid_word_t w;
        w = pending_words[0];
        in_valid_i <= 1'b1;
        in_kind_i <= w.kind;
        in_energy_i <= w.energy;
        in_angle_i <= w.angle;
        in_point_power_i <= w.point_power;
      end else if (!in_valid_i || !in_stall_o) begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        interp_word_t e;
        if (expected_results.size() == 0) begin
          $error("result word with no expectation: power %0d status %0d",
                 out_power_o, out_status_o);
          error_count++;
        end else begin
          e = expected_results.pop_front();
          if (out_power_o !== e.power) begin
            $error("power: expected %0d actual %0d", e.power, out_power_o);
            error_count++;
          end
          if (out_status_o !== e.status) begin
            $error("status: expected %0d actual %0d", e.status, out_status_o);
            error_count++;
          end
        end
      end
      if (hold_cycles != 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
      end
    end
  end

  initial begin
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    error_count = 0;
    tbl_rows = 0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, extremes, order and full errors, unknown kind.
    push_word(make_word(KIND_QUERY, 32'd5, 16'd5, 16'd0));
    push_word(make_word(KIND_LOAD, 32'd0, 16'd0, 16'h8000));
    push_word(make_word(KIND_LOAD, 32'd0, 16'd0, 16'd1));
    push_word(make_word(KIND_LOAD, 32'd0, 16'hFFFF, 16'h7FFF));
    push_word(make_word(KIND_QUERY, 32'd0, 16'd100, 16'd0));
    push_word(make_word(KIND_LOAD, 32'hFFFF_FFFF, 16'd0, 16'h7FFF));
    push_word(make_word(KIND_LOAD, 32'hFFFF_FFFF, 16'hFFFF, 16'h8000));
    push_word(make_word(KIND_LOAD, 32'd7, 16'd1, 16'd1));
    push_word(make_word(KIND_QUERY, 32'h8000_0000, 16'h7FFF, 16'hFFFF));
    push_word(make_word(KIND_QUERY, 32'hFFFF_FFFF, 16'd1, 16'd0));
    push_word(make_word(KIND_QUERY, 32'd0, 16'hFFFF, 16'd0));
    push_word(make_word(2'd3, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
    push_word(make_word(KIND_CLEAR, 32'd0, 16'd0, 16'd0));
    push_word(make_word(KIND_LOAD, 32'd10, 16'd50, 16'd300));
    push_word(make_word(KIND_LOAD, 32'd20, 16'd40, 16'd100));
    push_word(make_word(KIND_LOAD, 32'd20, 16'd60, 16'hFF00));
    push_word(make_word(KIND_QUERY, 32'd15, 16'd50, 16'd0));
    push_word(make_word(KIND_QUERY, 32'd9, 16'd50, 16'd0));
    for (int r = 0; r < MAX_ROWS + 1; r++)
      push_word(make_word(KIND_LOAD, 32'd100 + r, 16'd0, 16'(r)));
    for (int p = 0; p < MAX_PTS + 1; p++)
      push_word(make_word(KIND_LOAD, 32'd500, 16'(p + 1), 16'(p * 997)));
    for (int p = 0; p < MAX_PTS; p++)
      push_word(make_word(KIND_QUERY, 32'd120, 16'(p), 16'd0));
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? 73 : (phase == 2 ? 6 : 0);
      recv_stall_pct = (phase == 2 || phase == 3) ? 73 : (phase == 1 ? 6 : 0);
      if (phase == 3) begin
        send_idle_pct = 6;
        recv_stall_pct = 6;
      end
      for (int t = 0; t < 10; t++) begin
        if ($urandom_range(0, 9) == 0)
          push_random_table($urandom_range(2, MAX_ROWS), $urandom_range(1, 4));
        else
          push_random_table($urandom_range(1, 5), $urandom_range(1, 6));
        if (t == 3 && phase == 0) hold_cycles = 3000;
        if (t == 5) begin
          while (expected_results.size() != 0 || pending_words.size() != 0)
            @(posedge clk_i);
        end
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
